>>> rtl/core/smc_pkg.sv
// Shared types and codes of the stack machine execute unit.
package smc_pkg;

    // Instruction codes
    localparam logic [4:0] OP_POP      = 5'd0;
    localparam logic [4:0] OP_PUSH     = 5'd1;
    localparam logic [4:0] OP_DUPE     = 5'd2;
    localparam logic [4:0] OP_SWAP     = 5'd3;
    localparam logic [4:0] OP_ROT      = 5'd4;
    localparam logic [4:0] OP_ADD      = 5'd5;
    localparam logic [4:0] OP_SUB      = 5'd6;
    localparam logic [4:0] OP_MULT     = 5'd7;
    localparam logic [4:0] OP_DIV      = 5'd8;
    localparam logic [4:0] OP_SHL      = 5'd9;
    localparam logic [4:0] OP_SHR      = 5'd10;
    localparam logic [4:0] OP_PRINTS   = 5'd11;
    localparam logic [4:0] OP_PRINTC   = 5'd12;
    localparam logic [4:0] OP_PRINTNUM = 5'd13;
    localparam logic [4:0] OP_JMPZ     = 5'd14;
    localparam logic [4:0] OP_JMPL     = 5'd15;
    localparam logic [4:0] OP_JMPG     = 5'd16;
    localparam logic [4:0] OP_HALT     = 5'd17;

    // Fault codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
    localparam logic [2:0] ERR_INDEX     = 3'd3;
    localparam logic [2:0] ERR_TARGET    = 3'd4;
    localparam logic [2:0] ERR_DIVZERO   = 3'd5;
    localparam logic [2:0] ERR_OPCODE    = 3'd6;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_CHAR   = 2'd2;

    // Configuration register indexes
    localparam int unsigned REG_PROGRAM_LENGTH = 0;

    // String terminator
    localparam logic [7:0] CHAR_NUL = 8'd0;

    // Per-cell source select
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_UP   = 2'd1,
        CELL_DOWN = 2'd2,
        CELL_LOAD = 2'd3
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t   sel;
        logic [31:0] load_data;
    } cell_ctrl_t;

endpackage

>>> rtl/core/smc_if.sv
// Request and result channel interfaces of the stack machine execute unit.
interface smc_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  opcode;
    logic signed [31:0] operand;

    modport source (output valid, output opcode, output operand, input ready);
    modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface smc_out_if #(parameter int DEPTH_W = 5);
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [15:0]        next_ip;
    logic [DEPTH_W-1:0] depth;
    logic               halted;
    logic [2:0]         error_code;
    logic               last;

    modport source (output valid, output kind, output value, output next_ip, output depth,
                    output halted, output error_code, output last, input ready);
    modport sink   (input valid, input kind, input value, input next_ip, input depth,
                    input halted, input error_code, input last, output ready);
endinterface

>>> rtl/core/smc_cell.sv
// One stack entry cell: holds, shifts from a neighbor or loads a value.
module smc_cell (
    input  logic              clk,
    input  smc_pkg::cell_ctrl_t ctrl,
    input  logic [31:0]       upper_data,
    input  logic [31:0]       lower_data,
    output logic [31:0]       data_q
);
    import smc_pkg::*;

    logic [31:0] data_reg;
    logic [31:0] data_next;

    // Select the new entry value
    always_comb
    begin
        unique case (ctrl.sel)
            CELL_UP:   data_next = upper_data;
            CELL_DOWN: data_next = lower_data;
            CELL_LOAD: data_next = ctrl.load_data;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;
endmodule

>>> rtl/core/smc_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
module smc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  count_reg, count_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] trial;

    // Step the restoring division
    always_comb
    begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        shifted    = {rem_reg[31:0], quo_reg[31]};
        trial      = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next   = '0;
            quo_next   = dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_next   = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next   = dividend[31] ^ divisor[31];
            count_next = 6'd32;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            count_next = count_reg - 6'd1;
            if (count_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;
endmodule

>>> rtl/core/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: control, cell chain and result emission.
//
//  channel  | dir | handshake      | payload
//  in_ch    | in  | valid/ready    | opcode, operand
//  out_ch   | out | valid/ready    | kind, value, next_ip, depth, halted, error_code, last
//  apb      | in  | psel/penable   | paddr, pwdata -> prdata (program_length)
//
// One instruction at a time. Most instructions finish in the accept cycle and show
// their first result in the next cycle; a div that starts the divider waits in S_DIV
// until the quotient is done, then commits it and shows its result; prints pops one
// cell per cycle until a terminator or an empty stack. Each result is held on out_ch
// until it is taken; in_ch is ready only when the last result is gone.
// rst_n clears depth, ip, halt and fault; stack cells are not reset.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    smc_in_if.sink      in_ch,
    smc_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import smc_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_STR  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic [15:0]    ip_reg, ip_next;
    logic           halt_reg, halt_next;
    logic [2:0]     fault_reg, fault_next;
    logic [15:0]    len_reg;
    logic [DW-1:0]  cnt_reg, cnt_next;
    logic [DW-1:0]  emit_reg, emit_next;
    logic [1:0]     kind_reg, kind_next;
    logic [31:0]    buf_reg [STACK_DEPTH];
    logic           buf_we;
    logic [31:0]    buf_wdata;

    logic [31:0]    cell_q [STACK_DEPTH];
    cell_ctrl_t     ctrl [STACK_DEPTH];
    logic [31:0]    push_data;

    logic           div_start;
    logic           div_done;
    logic [31:0]    div_quo;

    logic [31:0]    opd;
    logic [31:0]    a_top;
    logic [31:0]    b_sec;
    logic [31:0]    alu_res;
    logic [DW-1:0]  dupe_rel;
    logic [31:0]    depth_ext;
    logic           take;
    logic           accept;
    logic           emit_last;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {16'd0, len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (psel && penable && pwrite && (32'(paddr >> 2) == REG_PROGRAM_LENGTH))
        begin
            len_reg <= pwdata[15:0];
        end
    end

    // Cell chain: cell 0 is the top of stack
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [31:0] up_d;
        logic [31:0] low_d;
        if (i == 0)
        begin : g_top
            assign up_d = push_data;
        end
        else
        begin : g_mid
            assign up_d = cell_q[i-1];
        end
        if (i == STACK_DEPTH - 1)
        begin : g_bot
            assign low_d = '0;
        end
        else
        begin : g_upper
            assign low_d = cell_q[i+1];
        end
        smc_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[i]),
            .upper_data (up_d),
            .lower_data (low_d),
            .data_q     (cell_q[i])
        );
    end

    smc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_top),
        .divisor  (b_sec),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Operands and arithmetic
    assign opd       = 32'(in_ch.operand);
    assign a_top     = cell_q[0];
    assign b_sec     = cell_q[1];
    assign depth_ext = 32'(depth_reg);
    assign dupe_rel  = depth_reg - DW'(1) - opd[DW-1:0];
    assign accept    = in_ch.valid && in_ch.ready;

    always_comb
    begin
        unique case (in_ch.opcode)
            OP_ADD:  alu_res = a_top + b_sec;
            OP_SUB:  alu_res = a_top - b_sec;
            OP_MULT: alu_res = a_top * b_sec;
            OP_SHL:  alu_res = a_top << b_sec[4:0];
            OP_SHR:  alu_res = 32'($signed(a_top) >>> b_sec[4:0]);
            default: alu_res = a_top;
        endcase
    end

    always_comb
    begin
        unique case (in_ch.opcode)
            OP_JMPZ: take = (a_top == 32'd0);
            OP_JMPL: take = a_top[31];
            default: take = (a_top != 32'd0) && !a_top[31];
        endcase
    end

    // Sequence one instruction
    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        ip_next    = ip_reg;
        halt_next  = halt_reg;
        fault_next = fault_reg;
        cnt_next   = cnt_reg;
        emit_next  = emit_reg;
        kind_next  = kind_reg;
        buf_we     = 1'b0;
        buf_wdata  = '0;
        push_data  = opd;
        div_start  = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            ctrl[i].sel       = CELL_HOLD;
            ctrl[i].load_data = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    emit_next  = '0;
                    kind_next  = KIND_STATUS;
                    state_next = S_EMIT;
                    if (!halt_reg && fault_reg == ERR_NONE && ip_reg < len_reg)
                    begin
                        unique case (in_ch.opcode)
                            OP_POP:
                            begin
                                if (depth_reg == '0)
                                    fault_next = ERR_UNDERFLOW;
                                else
                                begin
                                    for (int i = 0; i < STACK_DEPTH; i++)
                                        ctrl[i].sel = CELL_DOWN;
                                    depth_next = depth_reg - DW'(1);
                                    ip_next    = ip_reg + 16'd1;
                                end
                            end
                            OP_PUSH, OP_DUPE:
                            begin
                                if (in_ch.opcode == OP_DUPE && (opd[31] || opd >= depth_ext))
                                    fault_next = ERR_INDEX;
                                else if (depth_reg == DW'(STACK_DEPTH))
                                    fault_next = ERR_OVERFLOW;
                                else
                                begin
                                    if (in_ch.opcode == OP_DUPE)
                                        push_data = cell_q[dupe_rel[IW-1:0]];
                                    for (int i = 0; i < STACK_DEPTH; i++)
                                        ctrl[i].sel = CELL_UP;
                                    depth_next = depth_reg + DW'(1);
                                    ip_next    = ip_reg + 16'd1;
                                end
                            end
                            OP_SWAP:
                            begin
                                if (depth_reg < DW'(2))
                                    fault_next = ERR_UNDERFLOW;
                                else
                                begin
                                    ctrl[0].sel       = CELL_LOAD;
                                    ctrl[0].load_data = cell_q[1];
                                    ctrl[1].sel       = CELL_LOAD;
                                    ctrl[1].load_data = cell_q[0];
                                    ip_next           = ip_reg + 16'd1;
                                end
                            end
                            OP_ROT:
                            begin
                                if (depth_reg < DW'(3))
                                    fault_next = ERR_UNDERFLOW;
                                else
                                begin
                                    ctrl[0].sel       = CELL_DOWN;
                                    ctrl[1].sel       = CELL_DOWN;
                                    ctrl[2].sel       = CELL_LOAD;
                                    ctrl[2].load_data = cell_q[0];
                                    ip_next           = ip_reg + 16'd1;
                                end
                            end
                            OP_ADD, OP_SUB, OP_MULT, OP_SHL, OP_SHR, OP_DIV:
                            begin
                                if (depth_reg < DW'(2))
                                    fault_next = ERR_UNDERFLOW;
                                else if (in_ch.opcode == OP_DIV)
                                begin
                                    if (b_sec == 32'd0)
                                        fault_next = ERR_DIVZERO;
                                    else
                                    begin
                                        div_start  = 1'b1;
                                        state_next = S_DIV;
                                    end
                                end
                                else
                                begin
                                    for (int i = 1; i < STACK_DEPTH; i++)
                                        ctrl[i].sel = CELL_DOWN;
                                    ctrl[0].sel       = CELL_LOAD;
                                    ctrl[0].load_data = alu_res;
                                    depth_next        = depth_reg - DW'(1);
                                    ip_next           = ip_reg + 16'd1;
                                end
                            end
                            OP_PRINTS:
                            begin
                                kind_next  = KIND_CHAR;
                                state_next = S_STR;
                            end
                            OP_PRINTC, OP_PRINTNUM:
                            begin
                                if (depth_reg == '0)
                                    fault_next = ERR_UNDERFLOW;
                                else
                                begin
                                    for (int i = 0; i < STACK_DEPTH; i++)
                                        ctrl[i].sel = CELL_DOWN;
                                    depth_next = depth_reg - DW'(1);
                                    ip_next    = ip_reg + 16'd1;
                                    buf_we     = 1'b1;
                                    cnt_next   = DW'(1);
                                    if (in_ch.opcode == OP_PRINTC)
                                    begin
                                        kind_next = KIND_CHAR;
                                        buf_wdata = {24'd0, a_top[7:0]};
                                    end
                                    else
                                    begin
                                        kind_next = KIND_NUMBER;
                                        buf_wdata = a_top;
                                    end
                                end
                            end
                            OP_JMPZ, OP_JMPL, OP_JMPG:
                            begin
                                if (depth_reg == '0)
                                    fault_next = ERR_UNDERFLOW;
                                else if (take && (opd[31] || opd >= {16'd0, len_reg}))
                                    fault_next = ERR_TARGET;
                                else
                                begin
                                    for (int i = 0; i < STACK_DEPTH; i++)
                                        ctrl[i].sel = CELL_DOWN;
                                    depth_next = depth_reg - DW'(1);
                                    ip_next    = take ? opd[15:0] : ip_reg + 16'd1;
                                end
                            end
                            OP_HALT:
                            begin
                                halt_next = 1'b1;
                                ip_next   = ip_reg + 16'd1;
                            end
                            default:
                            begin
                                fault_next = ERR_OPCODE;
                            end
                        endcase
                    end
                end
            end
            S_DIV:
            begin
                // Commit the quotient in place of the top two entries
                if (div_done)
                begin
                    for (int i = 1; i < STACK_DEPTH; i++)
                        ctrl[i].sel = CELL_DOWN;
                    ctrl[0].sel       = CELL_LOAD;
                    ctrl[0].load_data = div_quo;
                    depth_next        = depth_reg - DW'(1);
                    ip_next           = ip_reg + 16'd1;
                    state_next        = S_EMIT;
                end
            end
            S_STR:
            begin
                // Pop one entry per cycle until a terminator or an empty stack
                if (depth_reg == '0)
                begin
                    fault_next = ERR_UNDERFLOW;
                    state_next = S_EMIT;
                end
                else
                begin
                    for (int i = 0; i < STACK_DEPTH; i++)
                        ctrl[i].sel = CELL_DOWN;
                    depth_next = depth_reg - DW'(1);
                    if (a_top[7:0] == CHAR_NUL)
                    begin
                        ip_next    = ip_reg + 16'd1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        buf_we    = 1'b1;
                        buf_wdata = {24'd0, a_top[7:0]};
                        cnt_next  = cnt_reg + DW'(1);
                    end
                end
            end
            S_EMIT:
            begin
                // Clear the print count on the way out so the next write starts at entry 0
                if (out_ch.ready)
                begin
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                        cnt_next   = '0;
                    end
                    else
                        emit_next = emit_reg + DW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            ip_reg    <= '0;
            halt_reg  <= 1'b0;
            fault_reg <= ERR_NONE;
            cnt_reg   <= '0;
            emit_reg  <= '0;
            kind_reg  <= KIND_STATUS;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            ip_reg    <= ip_next;
            halt_reg  <= halt_next;
            fault_reg <= fault_next;
            cnt_reg   <= cnt_next;
            emit_reg  <= emit_next;
            kind_reg  <= kind_next;
        end
    end

    // Printed values wait here until the instruction is done
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_reg[cnt_reg[IW-1:0]] <= buf_wdata;
        end
    end

    // Result emission
    assign emit_last        = (cnt_reg == '0) || (emit_reg + DW'(1) == cnt_reg);
    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = (state_reg == S_EMIT);
    assign out_ch.kind      = (cnt_reg == '0) ? KIND_STATUS : kind_reg;
    assign out_ch.value     = (cnt_reg == '0) ? 32'sd0 : $signed(buf_reg[emit_reg[IW-1:0]]);
    assign out_ch.next_ip   = ip_reg;
    assign out_ch.depth     = depth_reg;
    assign out_ch.halted    = halt_reg;
    assign out_ch.error_code = fault_reg;
    assign out_ch.last      = emit_last;
endmodule

>>> tb/stack_machine_execute_unit_tb.sv
// Self-checking testbench of the stack machine execute unit: directed table, random programs.
`timescale 1ns / 1ps

module stack_machine_execute_unit_tb;
    import smc_pkg::*;

    localparam int CAPACITY = 16;
    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [15:0] next_ip;
        logic [4:0]  depth;
        logic        halted;
        logic [2:0]  error_code;
        logic        last;
    } step_result_t;

    typedef struct {
        logic [4:0]  op;
        logic [31:0] opd;
        bit          typed;
        int          exp_depth;
        logic [2:0]  exp_err;
    } table_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    smc_in_if  in_ch ();
    smc_out_if #(.DEPTH_W(5)) out_ch ();

    stack_machine_execute_unit #(.STACK_DEPTH(CAPACITY)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Machine state as the testbench tracks it
    logic [31:0] stk [CAPACITY];
    int          stk_depth;
    logic [15:0] ip;
    logic        halt_seen;
    logic [2:0]  fault;
    logic [15:0] prog_len;

    step_result_t pending_results[$];
    int errors;
    int items_sent;
    int results_seen;
    int chars_seen;
    int cycles;
    bit send_steady;
    bit recv_steady;
    int hold_request;
    logic [2:0] tail_fault;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report(input string msg);
        errors++;
        if (errors <= 20)
            $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    function automatic bit jump_taken(input logic [4:0] op, input logic [31:0] a);
        if (op == OP_JMPZ)
            return a == 0;
        else if (op == OP_JMPL)
            return a[31];
        return (a != 0) && !a[31];
    endfunction

    // Advance the tracked machine by one instruction and queue its results
    task automatic execute_instr(input logic [4:0] op, input logic [31:0] opd);
        int d;
        int n;
        logic [15:0] nip;
        logic [2:0]  err;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [1:0]  kinds [CAPACITY + 1];
        logic [31:0] vals [CAPACITY + 1];
        longint quot;
        step_result_t r;

        n = 0;
        if (!halt_seen && fault == ERR_NONE && ip < prog_len)
        begin
            d = stk_depth;
            nip = ip + 16'd1;
            err = ERR_NONE;
            case (op)
                OP_POP:
                    if (d < 1) err = ERR_UNDERFLOW; else d--;
                OP_PUSH:
                    if (d >= CAPACITY) err = ERR_OVERFLOW;
                    else
                    begin
                        stk[d] = opd;
                        d++;
                    end
                OP_DUPE:
                    if (opd[31] || opd >= d) err = ERR_INDEX;
                    else if (d >= CAPACITY) err = ERR_OVERFLOW;
                    else
                    begin
                        stk[d] = stk[opd];
                        d++;
                    end
                OP_SWAP:
                    if (d < 2) err = ERR_UNDERFLOW;
                    else
                    begin
                        a = stk[d-1];
                        stk[d-1] = stk[d-2];
                        stk[d-2] = a;
                    end
                OP_ROT:
                    if (d < 3) err = ERR_UNDERFLOW;
                    else
                    begin
                        a = stk[d-1];
                        b = stk[d-2];
                        c = stk[d-3];
                        stk[d-3] = a;
                        stk[d-2] = c;
                        stk[d-1] = b;
                    end
                OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_SHL, OP_SHR:
                    if (d < 2) err = ERR_UNDERFLOW;
                    else
                    begin
                        a = stk[d-1];
                        b = stk[d-2];
                        c = 32'd0;
                        case (op)
                            OP_ADD:  c = a + b;
                            OP_SUB:  c = a - b;
                            OP_MULT: c = a * b;
                            OP_SHL:  c = a << b[4:0];
                            OP_SHR:  c = $signed(a) >>> b[4:0];
                            default:
                                if (b == 0) err = ERR_DIVZERO;
                                else
                                begin
                                    quot = longint'($signed(a)) / longint'($signed(b));
                                    c = quot[31:0];
                                end
                        endcase
                        if (err == ERR_NONE)
                        begin
                            d--;
                            stk[d-1] = c;
                        end
                    end
                OP_PRINTS:
                    forever
                    begin
                        if (d < 1)
                        begin
                            err = ERR_UNDERFLOW;
                            break;
                        end
                        d--;
                        a = {24'd0, stk[d][7:0]};
                        if (a[7:0] == CHAR_NUL)
                            break;
                        if (n < CAPACITY)
                        begin
                            kinds[n] = KIND_CHAR;
                            vals[n] = a;
                            n++;
                        end
                    end
                OP_PRINTC, OP_PRINTNUM:
                    if (d < 1) err = ERR_UNDERFLOW;
                    else
                    begin
                        d--;
                        kinds[0] = (op == OP_PRINTC) ? KIND_CHAR : KIND_NUMBER;
                        vals[0] = (op == OP_PRINTC) ? {24'd0, stk[d][7:0]} : stk[d];
                        n = 1;
                    end
                OP_JMPZ, OP_JMPL, OP_JMPG:
                    if (d < 1) err = ERR_UNDERFLOW;
                    else
                    begin
                        if (jump_taken(op, stk[d-1]))
                        begin
                            if (opd[31] || opd >= prog_len) err = ERR_TARGET;
                            else nip = opd[15:0];
                        end
                        if (err == ERR_NONE)
                            d--;
                    end
                OP_HALT:
                    halt_seen = 1'b1;
                default:
                    err = ERR_OPCODE;
            endcase
            if (err != ERR_NONE)
            begin
                fault = err;
                if (op == OP_PRINTS)
                    stk_depth = d;
            end
            else
            begin
                stk_depth = d;
                ip = nip;
            end
        end
        if (n == 0)
        begin
            kinds[0] = KIND_STATUS;
            vals[0] = 32'd0;
            n = 1;
        end
        for (int k = 0; k < n; k++)
        begin
            r.kind = kinds[k];
            r.value = vals[k];
            r.next_ip = ip;
            r.depth = stk_depth[4:0];
            r.halted = halt_seen;
            r.error_code = fault;
            r.last = (k == n - 1);
            pending_results.push_back(r);
        end
    endtask

    // Offer one request and wait until it is taken
    task automatic send_instr(input logic [4:0] op, input logic [31:0] opd);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.operand <= opd;
        do @(posedge clk); while (!in_ch.ready);
        execute_instr(op, opd);
        items_sent++;
    endtask

    task automatic write_prog_len(input logic [15:0] len);
        @(posedge clk);
        in_ch.valid <= 1'b0;
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'(REG_PROGRAM_LENGTH * 4);
        pwdata <= {16'd0, len};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        prog_len = len;
    endtask

    // Drain every expected result, then let the block settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            5: return $urandom & 32'hFFFF_FF00;
            6: return $urandom_range(32, 126);
            default: return $urandom;
        endcase
    endfunction

    // Draw an instruction that keeps the machine running
    task automatic pick_instr(output logic [4:0] op, output logic [31:0] opd);
        int d;
        bit ok;
        bit term;
        d = stk_depth;
        op = 5'($urandom_range(0, 16));
        opd = rand_word();
        ok = 1'b1;
        case (op)
            OP_POP, OP_PRINTC, OP_PRINTNUM: ok = d >= 1;
            OP_PUSH: ok = d < CAPACITY;
            OP_DUPE:
            begin
                ok = d >= 1 && d < CAPACITY;
                if (ok) opd = $urandom_range(0, d - 1);
            end
            OP_SWAP, OP_ADD, OP_SUB, OP_MULT, OP_SHL, OP_SHR: ok = d >= 2;
            OP_ROT: ok = d >= 3;
            OP_DIV: ok = d >= 2 && stk[d-2] != 0;
            OP_PRINTS:
            begin
                term = 1'b0;
                for (int i = 0; i < d; i++)
                    if (stk[i][7:0] == CHAR_NUL) term = 1'b1;
                ok = term;
            end
            OP_JMPZ, OP_JMPL, OP_JMPG:
            begin
                ok = d >= 1 && prog_len > 0;
                if (ok)
                begin
                    if ($urandom_range(0, 3) != 0)
                        opd = $urandom_range(0, (prog_len > 60000) ? 60000 : prog_len - 1);
                    if (jump_taken(op, stk[d-1]) && (opd[31] || opd >= prog_len))
                        opd = $urandom_range(0, ip);
                end
            end
            default: ok = 1'b1;
        endcase
        if (!ok)
        begin
            if (d == 0 || (d < CAPACITY && (d < 8 || $urandom_range(0, 1))))
            begin
                op = OP_PUSH;
                opd = rand_word();
            end
            else
            begin
                op = OP_POP;
            end
        end
    endtask

    task automatic run_random(input int count);
        logic [4:0]  op;
        logic [31:0] opd;
        for (int i = 0; i < count; i++)
        begin
            if (i % 30 == 0)
                send_steady = ($urandom_range(0, 3) == 0);
            pick_instr(op, opd);
            send_instr(op, opd);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        step_result_t e;
        if (out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (out_ch.kind == KIND_CHAR)
                chars_seen++;
            if (pending_results.size() == 0)
                report("result with nothing expected");
            else
            begin
                e = pending_results.pop_front();
                if (out_ch.kind !== e.kind)
                    report($sformatf("kind %0d exp %0d", out_ch.kind, e.kind));
                if (out_ch.value !== e.value)
                    report($sformatf("value %h exp %h", out_ch.value, e.value));
                if (out_ch.next_ip !== e.next_ip)
                    report($sformatf("next_ip %0d exp %0d", out_ch.next_ip, e.next_ip));
                if (out_ch.depth !== e.depth)
                    report($sformatf("depth %0d exp %0d", out_ch.depth, e.depth));
                if (out_ch.halted !== e.halted)
                    report($sformatf("halted %0d exp %0d", out_ch.halted, e.halted));
                if (out_ch.error_code !== e.error_code)
                    report($sformatf("error_code %0d exp %0d", out_ch.error_code,
                                     e.error_code));
                if (out_ch.last !== e.last)
                    report($sformatf("last %0d exp %0d", out_ch.last, e.last));
            end
        end
    end

    // Result receiver: random stalls, bursts, and one long hold-off on request
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            if ($urandom_range(0, 40) == 0)
                recv_steady = ~recv_steady;
            stall = recv_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // Directed program: extremes, every operation but pop and jmpz, string and jump cases
    table_row_t directed [] = '{
        '{OP_PUSH,     32'h7FFF_FFFF, 1, 1, ERR_NONE},
        '{OP_PUSH,     32'h8000_0000, 1, 2, ERR_NONE},
        '{OP_ADD,      32'd0,         1, 1, ERR_NONE},
        '{OP_PUSH,     32'hFFFF_FFFF, 0, 0, ERR_NONE},
        '{OP_PUSH,     32'h8000_0000, 0, 0, ERR_NONE},
        '{OP_DIV,      32'd0,         1, 2, ERR_NONE},
        '{OP_PUSH,     32'd31,        0, 0, ERR_NONE},
        '{OP_SWAP,     32'd0,         0, 0, ERR_NONE},
        '{OP_SHL,      32'd0,         0, 0, ERR_NONE},
        '{OP_PUSH,     32'd33,        0, 0, ERR_NONE},
        '{OP_SWAP,     32'd0,         0, 0, ERR_NONE},
        '{OP_SHR,      32'd0,         0, 0, ERR_NONE},
        '{OP_MULT,     32'd0,         0, 0, ERR_NONE},
        '{OP_DUPE,     32'd0,         1, 2, ERR_NONE},
        '{OP_SUB,      32'd0,         1, 1, ERR_NONE},
        '{OP_PUSH,     32'h0000_0100, 0, 0, ERR_NONE},
        '{OP_PUSH,     32'h0000_0148, 0, 0, ERR_NONE},
        '{OP_PUSH,     32'd105,       0, 0, ERR_NONE},
        '{OP_ROT,      32'd0,         0, 0, ERR_NONE},
        '{OP_PRINTS,   32'd0,         0, 0, ERR_NONE},
        '{OP_PRINTC,   32'h0001_2345, 0, 0, ERR_NONE},
        '{OP_PRINTNUM, 32'd0,         0, 0, ERR_NONE},
        '{OP_JMPL,     32'd65535,     0, 0, ERR_NONE},
        '{OP_JMPG,     32'd3,         0, 0, ERR_NONE},
        '{OP_HALT,     32'd0,         0, 0, ERR_NONE}
    };

    // Main sequence
    initial
    begin
        logic [4:0]  op;
        logic [31:0] opd;

        errors = 0;
        items_sent = 0;
        results_seen = 0;
        chars_seen = 0;
        cycles = 0;
        send_steady = 1'b0;
        recv_steady = 1'b0;
        hold_request = 0;
        stk_depth = 0;
        ip = 16'd0;
        halt_seen = 1'b0;
        fault = ERR_NONE;
        prog_len = 16'd0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 2'd0;
        pwdata = 32'd0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_POP;
        in_ch.operand = 32'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty program: every request is ignored, any opcode goes
        for (int i = 0; i < 8; i++)
            send_instr(5'($urandom_range(0, 31)), $urandom);
        wait_idle();
        write_prog_len(16'hFFFF);

        // Directed rows; the halt row is held back so the machine keeps running
        for (int i = 0; i < directed.size() - 1; i++)
        begin
            if (directed[i].op == OP_JMPL || directed[i].op == OP_JMPG)
                send_instr(OP_PUSH, (directed[i].op == OP_JMPL) ? 32'd5 : 32'd7);
            send_instr(directed[i].op, directed[i].opd);
            if (directed[i].typed && (stk_depth != directed[i].exp_depth
                                      || fault != directed[i].exp_err))
                report($sformatf("directed row %0d: depth %0d fault %0d", i, stk_depth,
                                 fault));
        end
        send_instr(OP_PUSH, 32'd0);
        send_instr(OP_JMPZ, 32'd0);

        run_random(110);

        // Long receiver hold-off while requests keep coming
        hold_request = 400;
        run_random(20);
        wait_idle();

        // Short program: run off its end, then extend it again
        write_prog_len(ip + 16'd2);
        run_random(6);
        wait_idle();
        write_prog_len(16'hFFFF);
        run_random(110);

        // Freeze the machine one way, chosen at random, and poke it
        tail_fault = 3'($urandom_range(0, 6));
        case (tail_fault)
            ERR_UNDERFLOW:
            begin
                while (stk_depth > 0) send_instr(OP_POP, 32'd0);
                send_instr(OP_SWAP, 32'd0);
            end
            ERR_OVERFLOW:
            begin
                while (stk_depth < CAPACITY) send_instr(OP_PUSH, rand_word());
                send_instr(OP_DUPE, 32'd0);
            end
            ERR_INDEX:
                send_instr(OP_DUPE, $urandom_range(0, 1) ? 32'hFFFF_FFFF : stk_depth);
            ERR_TARGET:
            begin
                while (stk_depth > CAPACITY - 2) send_instr(OP_POP, 32'd0);
                send_instr(OP_PUSH, 32'd0);
                send_instr(OP_JMPZ, 32'hFFFF);
            end
            ERR_DIVZERO:
            begin
                while (stk_depth > CAPACITY - 2) send_instr(OP_POP, 32'd0);
                send_instr(OP_PUSH, 32'd0);
                send_instr(OP_PUSH, 32'd9);
                send_instr(OP_DIV, 32'd0);
            end
            ERR_OPCODE:
                send_instr(5'($urandom_range(18, 31)), $urandom);
            default:
                send_instr(OP_HALT, $urandom);
        endcase
        if (fault != tail_fault || (tail_fault == ERR_NONE && !halt_seen))
            report($sformatf("freeze: fault %0d halted %0d", fault, halt_seen));
        for (int i = 0; i < 6; i++)
        begin
            pick_instr(op, opd);
            send_instr(5'($urandom_range(0, 31)), opd);
        end

        wait_idle();
        $display("covered %0d requests, %0d results (%0d characters), freeze code %0d",
                 items_sent, results_seen, chars_seen, tail_fault);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/smc_pkg.sv
rtl/core/smc_if.sv
rtl/core/smc_cell.sv
rtl/core/smc_div.sv
rtl/core/stack_machine_execute_unit.sv
tb/stack_machine_execute_unit_tb.sv
